// ----- rtl/core/mvrld_pkg.sv -----
// ----------------------------------------------------------------------------
// mvrld_pkg
// Shared types, constants and float helpers for the missing value run
// length decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package mvrld_pkg;

	localparam int unsigned MaxOutputWords = 65536;
	localparam int unsigned RunW = 17;
	localparam int unsigned CfgIdxW = 8;

	localparam logic [1:0] StOk       = 2'd0;
	localparam logic [1:0] StMarkLast = 2'd1;
	localparam logic [1:0] StBadCount = 2'd2;
	localparam logic [1:0] StShort    = 2'd3;

	localparam logic [CfgIdxW-1:0] RegMissingValue = 8'd0;
	localparam logic [CfgIdxW-1:0] RegOutputWords  = 8'd1;

	typedef struct packed {
		logic [63:0] word;
		logic        final_word;
	} in_word_t;

	typedef struct packed {
		logic [63:0]     value;
		logic [RunW-1:0] run_length;
		logic            done_res;
		logic [1:0]      status;
	} out_word_t;

	// word kind decided by the front part
	localparam logic [1:0] KindLiteral = 2'd0;
	localparam logic [1:0] KindMarker  = 2'd1;
	localparam logic [1:0] KindCount   = 2'd2;

	// classified count: rounded value in 25 bits, with bad and big flags
	typedef struct packed {
		logic            bad;       // nan or rounds below zero
		logic            big;       // at least 2^24
		logic [24:0]     n;         // truncate(0.5 + x) when not big
	} count_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] word;
		logic        final_word;
		count_t      cnt;
	} fe_word_t;

	// double equality compare (ieee semantics)
	function automatic logic dbl_eq(input logic [63:0] a, input logic [63:0] b);
		logic a_nan, b_nan, both_zero;
		a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
		b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
		both_zero = (a[62:0] == '0) && (b[62:0] == '0);
		return !a_nan && !b_nan && ((a == b) || both_zero);
	endfunction

	// rounding of a count: truncate(0.5 + x)
	function automatic count_t round_count(input logic [63:0] x);
		count_t r;
		logic [10:0] e;
		logic [52:0] m;
		logic [78:0] sh;
		logic [11:0] k;
		e = x[62:52];
		m = {1'b1, x[51:0]};
		r = '0;
		sh = '0;
		k = '0;
		if (e == 11'h7ff && x[51:0] != '0) begin
			r.bad = 1'b1;
		end else if (x[63]) begin
			// negative: 0.5+x <= -1 iff x <= -1.5
			if (e > 11'd1023 || (e == 11'd1023 && x[51] == 1'b1))
				r.bad = 1'b1;
		end else if (e >= 11'd1047) begin
			r.big = 1'b1;
		end else if (e >= 11'd1022) begin
			// value = m * 2^(e-1075); keep one fraction bit for the 0.5 add
			k = 12'd1075 - {1'b0, e} - 12'd1;
			sh = {m, 26'd0} >> k;
			r.n = 25'((sh[78:26] + 53'd1) >> 1);
		end else if (x[62:0] == 63'h3fdf_ffff_ffff_ffff) begin
			// largest double below one half: the 0.5 add rounds up to 1.0
			r.n = 25'd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mvrld_front.sv -----
// ----------------------------------------------------------------------------
// mvrld_front
// Accepts input words, classifies literal, marker or count, and rounds
// counts; pushes classified words to the back stage.
// ----------------------------------------------------------------------------
`default_nettype none
module mvrld_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire mvrld_pkg::in_word_t in_data,
	input  wire logic [63:0]         missing_value,
	output logic                     fe_valid,
	input  wire logic                fe_stall,
	output mvrld_pkg::fe_word_t      fe_data
);
	logic                 valid_s1;
	mvrld_pkg::fe_word_t  data_s1;
	logic                 expect_q;
	logic                 take;

	assign in_stall = valid_s1 && fe_stall;
	assign take = in_valid && !in_stall;
	assign fe_valid = valid_s1;
	assign fe_data = data_s1;

	// expecting_count tracking; cleared after a count word or on a final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			expect_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (take) begin
				if (in_data.final_word)
					expect_q <= 1'b0;
				else if (expect_q)
					expect_q <= 1'b0;
				else
					expect_q <= mvrld_pkg::dbl_eq(in_data.word, missing_value);
			end
		end
	end

	// classify stage
	always_ff @(posedge clk) begin
		if (take) begin
			data_s1.word <= in_data.word;
			data_s1.final_word <= in_data.final_word;
			data_s1.cnt <= mvrld_pkg::round_count(in_data.word);
			if (expect_q)
				data_s1.kind <= mvrld_pkg::KindCount;
			else if (mvrld_pkg::dbl_eq(in_data.word, missing_value))
				data_s1.kind <= mvrld_pkg::KindMarker;
			else
				data_s1.kind <= mvrld_pkg::KindLiteral;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/mvrld_back.sv -----
// ----------------------------------------------------------------------------
// mvrld_back
// Executes classified words: tracks output count, stop and errors, and
// produces run descriptors into an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module mvrld_back #(
	parameter int unsigned MAX_OUTPUT_WORDS = mvrld_pkg::MaxOutputWords
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fe_valid,
	output logic                      fe_stall,
	input  wire mvrld_pkg::fe_word_t  fe_data,
	input  wire logic [63:0]          missing_value,
	input  wire logic [16:0]          output_words,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output mvrld_pkg::out_word_t      out_data
);
	localparam int unsigned CntW = $clog2(MAX_OUTPUT_WORDS + 1) + 1;

	logic [CntW-1:0]       written_q;
	logic                  stopped_q;
	logic                  valid_q;
	mvrld_pkg::out_word_t  data_q;
	logic [CntW-1:0]       lim, remaining, n_ext, sum;
	logic                  take, emit, done;
	logic [1:0]            st;
	logic [63:0]           val;
	logic [16:0]           run;

	assign fe_stall = valid_q && out_stall;
	assign take = fe_valid && !fe_stall;
	assign out_valid = valid_q;
	assign out_data = data_q;

	// limit and remaining words
	always_comb begin
		lim = (CntW'(output_words) > CntW'(MAX_OUTPUT_WORDS)) ?
			CntW'(MAX_OUTPUT_WORDS) : CntW'(output_words);
		remaining = lim - written_q;
		n_ext = (fe_data.cnt.n > 25'((1 << (CntW - 1)) - 1)) ?
			CntW'((1 << (CntW - 1)) - 1) : CntW'(fe_data.cnt.n);
	end

	// decision for one word
	always_comb begin
		emit = 1'b0; done = 1'b0; st = mvrld_pkg::StOk;
		val = '0; run = '0; sum = written_q;
		if (written_q >= lim) begin
			emit = 1'b1; done = 1'b1;
		end else begin
			case (fe_data.kind)
				mvrld_pkg::KindCount: begin
					if (fe_data.cnt.bad) begin
						emit = 1'b1; done = 1'b1; st = mvrld_pkg::StBadCount;
					end else if (!fe_data.cnt.big && fe_data.cnt.n == '0) begin
						if (fe_data.final_word) begin
							emit = 1'b1; done = 1'b1; st = mvrld_pkg::StShort;
						end
					end else if (fe_data.cnt.big || n_ext > remaining) begin
						emit = 1'b1; done = 1'b1; st = mvrld_pkg::StBadCount;
						val = missing_value; run = 17'(remaining); sum = lim;
					end else begin
						sum = written_q + n_ext;
						emit = 1'b1; val = missing_value; run = 17'(n_ext);
						if (sum >= lim) done = 1'b1;
						else if (fe_data.final_word) begin
							done = 1'b1; st = mvrld_pkg::StShort;
						end
					end
				end
				mvrld_pkg::KindMarker: begin
					if (fe_data.final_word) begin
						emit = 1'b1; done = 1'b1; st = mvrld_pkg::StMarkLast;
					end
				end
				default: begin
					sum = written_q + 1'b1;
					emit = 1'b1; val = fe_data.word; run = 17'd1;
					if (sum >= lim) done = 1'b1;
					else if (fe_data.final_word) begin
						done = 1'b1; st = mvrld_pkg::StShort;
					end
				end
			endcase
		end
		if (stopped_q) emit = 1'b0;
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			stopped_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (!fe_stall)
				valid_q <= take && emit;
			if (take) begin
				if (fe_data.final_word) begin
					written_q <= '0;
					stopped_q <= 1'b0;
				end else if (!stopped_q) begin
					written_q <= sum;
					if (emit && done) stopped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			data_q.value <= val;
			data_q.run_length <= run;
			data_q.done_res <= done;
			data_q.status <= st;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/missing_value_run_length_decoder.sv -----
// ----------------------------------------------------------------------------
// missing_value_run_length_decoder
// Decodes run-length coded missing values from a stream of double words.
// ----------------------------------------------------------------------------
// Usage: words enter on in_valid/in_stall/in_data, run descriptors leave on
// out_valid/out_stall/out_data. A word is taken when valid is high and stall
// is low. Each word is classified (literal, marker, count) in the front
// stage, then executed in the back stage against the output count.
// A word passes the front register, then the output register; one word per
// cycle is sustained while out_stall is low, set by the single classify stage
// and single execute stage with its counter update. No-result words vanish.
// When the receiver stalls, the output register holds, the back stage then
// stalls the front stage, and in_stall rises; the state does not change.
// Reset clears the record state and empties both stages; registers return
// to missing_value 0 and output_words 1. Config writes land at once; the user
// must make them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
module missing_value_run_length_decoder #(
	parameter int unsigned MAX_OUTPUT_WORDS = mvrld_pkg::MaxOutputWords
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire mvrld_pkg::in_word_t                  in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output mvrld_pkg::out_word_t                      out_data,
	input  wire logic                                 cfg_we,
	input  wire logic [mvrld_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire logic [63:0]                          cfg_wdata
);
	logic [63:0]         missing_value_q;
	logic [16:0]         output_words_q;
	logic                fe_valid, fe_stall;
	mvrld_pkg::fe_word_t fe_data;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missing_value_q <= '0;
			output_words_q <= 17'd1;
		end else if (cfg_we) begin
			if (cfg_index == mvrld_pkg::RegMissingValue)
				missing_value_q <= cfg_wdata;
			else if (cfg_index == mvrld_pkg::RegOutputWords)
				output_words_q <= cfg_wdata[16:0];
		end
	end

	mvrld_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.missing_value(missing_value_q),
		.fe_valid(fe_valid), .fe_stall(fe_stall), .fe_data(fe_data)
	);

	mvrld_back #(.MAX_OUTPUT_WORDS(MAX_OUTPUT_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.fe_valid(fe_valid), .fe_stall(fe_stall), .fe_data(fe_data),
		.missing_value(missing_value_q), .output_words(output_words_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule
`default_nettype wire
